// ----- src/htfd_pkg.sv -----
package htfd_pkg;

    // crc-8 parameters
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // frame layout
    localparam int BUSY_BIT = 7;
    localparam logic [2:0] POS_FIRST = 3'd0;
    localparam logic [2:0] POS_LAST = 3'd6;

    // conversion constants
    localparam int HUM_SCALE = 10000;
    localparam int TEMP_SCALE = 20000;
    localparam int TEMP_OFFSET = 5000;

    // frame status codes
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_CRC_ERR = 2'd2;

    // one decoded frame waiting for conversion
    typedef struct packed {
        logic [19:0] hraw;
        logic [19:0] traw;
        logic [7:0]  crc;
        logic [1:0]  status;
    } htfd_rec_t;

    // queue fill state seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } htfd_qstat_t;

    // one byte folded into the crc, msb first
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- src/htfd_front.sv -----
module htfd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           frame_byte,
    input  logic                 frame_start,
    input  htfd_pkg::htfd_qstat_t q_stat,
    output logic                 push,
    output htfd_pkg::htfd_rec_t  push_rec
);
    import htfd_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  status_reg, status_next;
    logic [39:0] payload_reg, payload_next;
    logic        accept;
    logic        restart;

    // input stalls only while the queue cannot take a frame
    assign in_stall = q_stat.full;
    assign accept = in_valid && !in_stall;
    assign restart = frame_start || (pos_reg == POS_FIRST) || (pos_reg > POS_LAST);

    // record for the crc byte
    always_comb
    begin
        push_rec.hraw = payload_reg[39:20];
        push_rec.traw = payload_reg[19:0];
        push_rec.crc = crc_reg;
        if (status_reg[BUSY_BIT])
        begin
            push_rec.status = ST_BUSY;
        end
        else if (crc_reg != frame_byte)
        begin
            push_rec.status = ST_CRC_ERR;
        end
        else
        begin
            push_rec.status = ST_OK;
        end
    end

    // byte classification and frame state
    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        status_next = status_reg;
        payload_next = payload_reg;
        push = 1'b0;
        if (accept)
        begin
            if (restart)
            begin
                status_next = frame_byte;
                crc_next = crc_fold(CRC_INIT, frame_byte);
                payload_next = '0;
                pos_next = 3'd1;
            end
            else if (pos_reg < POS_LAST)
            begin
                crc_next = crc_fold(crc_reg, frame_byte);
                payload_next = {payload_reg[31:0], frame_byte};
                pos_next = pos_reg + 3'd1;
            end
            else
            begin
                push = 1'b1;
                pos_next = POS_FIRST;
                crc_next = CRC_INIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_FIRST;
            crc_reg <= CRC_INIT;
            status_reg <= '0;
            payload_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            status_reg <= status_next;
            payload_reg <= payload_next;
        end
    end

endmodule

// ----- src/htfd_queue.sv -----
module htfd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  htfd_pkg::htfd_rec_t   push_rec,
    input  logic                  pop,
    output htfd_pkg::htfd_rec_t   head_rec,
    output htfd_pkg::htfd_qstat_t q_stat
);
    import htfd_pkg::*;

    htfd_rec_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_stat.full = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);
    assign head_rec = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ----- src/htfd_back.sv -----
module htfd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  htfd_pkg::htfd_rec_t   head_rec,
    input  htfd_pkg::htfd_qstat_t q_stat,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [19:0]           humidity_raw,
    output logic [19:0]           temperature_raw,
    output logic [13:0]           humidity_centi_pct,
    output logic signed [14:0]    temperature_centi_c,
    output logic [7:0]            computed_crc,
    output logic [1:0]            frame_status
);
    import htfd_pkg::*;

    logic        valid_reg, valid_next;
    logic [19:0] hraw_reg, traw_reg;
    logic [13:0] hcent_reg, hcent_next;
    logic [14:0] tcent_reg, tcent_next;
    logic [7:0]  crc_reg;
    logic [1:0]  status_reg;
    logic [33:0] hprod;
    logic [34:0] tprod;
    logic [14:0] tscaled;

    // load the output register when it is free or being taken
    assign pop = !q_stat.empty && (!valid_reg || !out_stall);

    // fixed-point scaling, floor by dropping 20 fraction bits
    always_comb
    begin
        hprod = 34'(head_rec.hraw) * 34'(HUM_SCALE);
        tprod = 35'(head_rec.traw) * 35'(TEMP_SCALE);
        hcent_next = hprod[33:20];
        tscaled = tprod[34:20];
        tcent_next = tscaled - 15'(TEMP_OFFSET);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hraw_reg <= head_rec.hraw;
            traw_reg <= head_rec.traw;
            hcent_reg <= hcent_next;
            tcent_reg <= tcent_next;
            crc_reg <= head_rec.crc;
            status_reg <= head_rec.status;
        end
    end

    assign out_valid = valid_reg;
    assign humidity_raw = hraw_reg;
    assign temperature_raw = traw_reg;
    assign humidity_centi_pct = hcent_reg;
    assign temperature_centi_c = $signed(tcent_reg);
    assign computed_crc = crc_reg;
    assign frame_status = status_reg;

endmodule

// ----- src/humidity_temp_frame_decoder_core.sv -----
// humidity/temperature sensor frame decoder
//
// input channel (in_valid / in_stall): one frame byte per transaction in
// order status, five data bytes, crc; frame_start restarts the frame.
// a crc-8 (poly 0x31, init 0xff) runs over the first six bytes.
// output channel (out_valid / out_stall): one transaction per crc byte
// with raw readings, scaled humidity and temperature, crc and status.
// throughput: one byte per cycle while the queue is not full; the front decodes
// and checks each byte as it is taken and hands finished frames to a two-entry queue.
// the frame enters the queue as the crc byte is taken and moves on into the output
// register once that register is free or being taken; out_valid comes from it.
// when the receiver stalls, the result holds and the queue absorbs up to
// two more frames; in_stall rises only once the queue is full.
// reset clears the frame position, sets the crc to 0xff and empties the
// queue and output register.
module humidity_temp_frame_decoder_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         frame_byte,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [19:0]        humidity_raw,
    output logic [19:0]        temperature_raw,
    output logic [13:0]        humidity_centi_pct,
    output logic signed [14:0] temperature_centi_c,
    output logic [7:0]         computed_crc,
    output logic [1:0]         frame_status
);
    import htfd_pkg::*;

    htfd_qstat_t q_stat;
    htfd_rec_t   push_rec;
    htfd_rec_t   head_rec;
    logic        push;
    logic        pop;

    // byte decode and crc check
    htfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .frame_byte  (frame_byte),
        .frame_start (frame_start),
        .q_stat      (q_stat),
        .push        (push),
        .push_rec    (push_rec)
    );

    // frame queue
    htfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .q_stat   (q_stat)
    );

    // scaling and result register
    htfd_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .head_rec            (head_rec),
        .q_stat              (q_stat),
        .pop                 (pop),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .humidity_raw        (humidity_raw),
        .temperature_raw     (temperature_raw),
        .humidity_centi_pct  (humidity_centi_pct),
        .temperature_centi_c (temperature_centi_c),
        .computed_crc        (computed_crc),
        .frame_status        (frame_status)
    );

`ifndef SYNTHESIS
    // no frame is written into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full))
        else $error("frame pushed into full queue");

    // a full queue means the output register is occupied
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output register");

    // status code is one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_status == ST_OK || frame_status == ST_BUSY ||
                       frame_status == ST_CRC_ERR))
        else $error("undefined frame status");

    // scaled humidity stays below full scale
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (humidity_centi_pct <= 14'd9999))
        else $error("humidity out of range");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
    import htfd_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTED = 50;

    // one decoded reading as the block should present it
    typedef struct {
        logic [19:0]        hum_raw;
        logic [19:0]        temp_code;
        logic [13:0]        hum_centi;
        logic signed [14:0] temp_centi;
        logic [7:0]         crc;
        logic [1:0]         status;
    } reading_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         frame_byte = 8'h00;
    logic               frame_start = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [19:0]        humidity_raw;
    logic [19:0]        temperature_raw;
    logic [13:0]        humidity_centi_pct;
    logic signed [14:0] temperature_centi_c;
    logic [7:0]         computed_crc;
    logic [1:0]         frame_status;

    // frame tracking state of the predictor
    logic [2:0]  frame_pos = POS_FIRST;
    logic [7:0]  frame_crc = CRC_INIT;
    logic [7:0]  held_status = 8'h00;
    logic [39:0] frame_data = '0;
    reading_t    pending_readings[$];

    // traffic shaping
    bit quiet_phase = 1'b0;
    bit heavy_stall = 1'b0;
    int send_calm = 0;
    int stall_left = 0;
    int stall_calm = 0;
    int stall_roll;

    // bookkeeping
    int error_count = 0;
    int idle_cycles = 0;
    int bytes_sent = 0;
    int readings_checked = 0;
    int ok_seen = 0;
    int busy_seen = 0;
    int crc_err_seen = 0;

    humidity_temp_frame_decoder_core u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .frame_byte          (frame_byte),
        .frame_start         (frame_start),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .humidity_raw        (humidity_raw),
        .temperature_raw     (temperature_raw),
        .humidity_centi_pct  (humidity_centi_pct),
        .temperature_centi_c (temperature_centi_c),
        .computed_crc        (computed_crc),
        .frame_status        (frame_status)
    );

    always #5 clk = ~clk;

    // serial crc-8, one input bit per shift
    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[7] ^ data[i];
            r = {r[6:0], 1'b0};
            if (fb)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED)
        begin
            $display("error at %0t: %s", $time, msg);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
        begin
            report_error($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    // track one accepted byte, queue a reading on the crc byte
    task automatic predict_byte(input logic [7:0] b, input logic s);
        reading_t r;
        longint   scaled;
        if (s || frame_pos == POS_FIRST || frame_pos > POS_LAST)
        begin
            held_status = b;
            frame_crc = crc8_next(CRC_INIT, b);
            frame_data = '0;
            frame_pos = 3'd1;
        end
        else if (frame_pos < POS_LAST)
        begin
            frame_crc = crc8_next(frame_crc, b);
            frame_data = {frame_data[31:0], b};
            frame_pos = frame_pos + 3'd1;
        end
        else
        begin
            r.hum_raw = frame_data[39:20];
            r.temp_code = frame_data[19:0];
            scaled = (longint'(r.hum_raw) * HUM_SCALE) >>> 20;
            r.hum_centi = scaled[13:0];
            scaled = ((longint'(r.temp_code) * TEMP_SCALE) >>> 20) - TEMP_OFFSET;
            r.temp_centi = scaled[14:0];
            r.crc = frame_crc;
            if (held_status[BUSY_BIT])
            begin
                r.status = ST_BUSY;
            end
            else if (frame_crc != b)
            begin
                r.status = ST_CRC_ERR;
            end
            else
            begin
                r.status = ST_OK;
            end
            pending_readings.push_back(r);
            frame_pos = POS_FIRST;
            frame_crc = CRC_INIT;
        end
    endtask

    // one input transaction, called and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic s);
        int roll;
        if (!quiet_phase)
        begin
            if (send_calm > 0)
            begin
                send_calm--;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 12)
                begin
                    in_valid <= 1'b0;
                    frame_byte <= 8'($urandom);
                    frame_start <= 1'($urandom);
                    repeat ($urandom_range(1, 11)) @(negedge clk);
                end
                else if (roll < 15)
                begin
                    send_calm = $urandom_range(20, 60);
                end
            end
        end
        in_valid <= 1'b1;
        frame_byte <= b;
        frame_start <= s;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_byte(b, s);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] status, input logic [39:0] data,
                              input bit crc_good, input logic flag);
        logic [7:0] crc;
        crc = crc8_next(CRC_INIT, status);
        for (int i = 4; i >= 0; i--)
        begin
            crc = crc8_next(crc, data[i*8 +: 8]);
        end
        if (!crc_good)
        begin
            crc = crc ^ 8'($urandom_range(1, 255));
        end
        send_byte(status, flag);
        for (int i = 4; i >= 0; i--)
        begin
            send_byte(data[i*8 +: 8], 1'b0);
        end
        send_byte(crc, 1'b0);
    endtask

    // well-formed frame with random content, extremes mixed in
    task automatic send_random_frame();
        logic [7:0]  status;
        logic [39:0] data;
        int          pick;
        status = 8'($urandom);
        status[BUSY_BIT] = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            data = '0;
        end
        else if (pick == 1)
        begin
            data = '1;
        end
        else
        begin
            data = {8'($urandom), 32'($urandom)};
        end
        send_frame(status, data, $urandom_range(0, 4) != 0, $urandom_range(0, 9) != 0);
    endtask

    // frames mostly, truncated frames and loose bytes for the rest
    task automatic run_mixed_traffic(input int n);
        int stop_at;
        int roll;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
            begin
                send_random_frame();
            end
            else if (roll < 90)
            begin
                send_byte(8'($urandom), 1'b1);
                repeat ($urandom_range(0, 5)) send_byte(8'($urandom), 1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'($urandom));
            end
        end
    endtask

    // hold the sender until every queued reading is out
    task automatic wait_for_readings();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic test_directed_frames();
        // status byte at position zero without the start flag, all-ones data, good crc
        send_frame(8'h00, 40'hFF_FFFF_FFFF, 1'b1, 1'b0);
        // busy and bad crc together, busy wins; all-zero data
        send_frame(8'h80, 40'h00_0000_0000, 1'b0, 1'b1);
        // partial frame cut short by a restart
        send_byte(8'h3C, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_frame(8'h1C, 40'h7F_800F_F055, 1'b0, 1'b1);
    endtask

    task automatic test_backlog_drain();
        heavy_stall = 1'b1;
        repeat (20) send_random_frame();
        wait_for_readings();
        heavy_stall = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_mixed_traffic(1380);
    endtask

    task automatic test_streaming();
        quiet_phase = 1'b1;
        run_mixed_traffic(400);
    endtask

    // receiver stall bursts
    always @(negedge clk)
    begin
        if (quiet_phase)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (stall_calm > 0)
        begin
            out_stall <= 1'b0;
            stall_calm--;
        end
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < (heavy_stall ? 70 : 20))
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 10);
            end
            else
            begin
                out_stall <= 1'b0;
                if (stall_roll > 95)
                begin
                    stall_calm = $urandom_range(20, 60);
                end
            end
        end
    end

    // result check against the oldest pending reading
    task automatic check_reading();
        reading_t want;
        if (pending_readings.size() == 0)
        begin
            report_error("result with no frame pending");
        end
        else
        begin
            want = pending_readings.pop_front();
            check_field("humidity_raw", humidity_raw, want.hum_raw);
            check_field("temperature_raw", temperature_raw, want.temp_code);
            check_field("humidity_centi_pct", humidity_centi_pct, want.hum_centi);
            check_field("temperature_centi_c", temperature_centi_c, want.temp_centi);
            check_field("computed_crc", computed_crc, want.crc);
            check_field("frame_status", frame_status, want.status);
            readings_checked++;
            if (want.status == ST_OK)
            begin
                ok_seen++;
            end
            else if (want.status == ST_BUSY)
            begin
                busy_seen++;
            end
            else
            begin
                crc_err_seen++;
            end
        end
    endtask

    // output monitor and activity counter
    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            check_reading();
        end
    end

    // watchdog on stuck traffic
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_frames();
        test_backlog_drain();
        test_random_traffic();
        test_streaming();
        wait_for_readings();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("sent %0d frame bytes with restarts, truncation and stall bursts",
                 bytes_sent);
        $display("checked %0d readings: %0d ok, %0d busy, %0d crc mismatch",
                 readings_checked, ok_seen, busy_seen, crc_err_seen);
        if (error_count == 0 && pending_readings.size() == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
